### sv/tccw_pkg.sv
// Package for the text console cell writer: geometry, codes, item and state types.
package tccw_pkg;

  localparam int COLUMNS    = 80;
  localparam int ROWS       = 25;
  localparam int TAB_STEP   = 4;
  localparam int CELL_COUNT = COLUMNS * ROWS;
  localparam int ADDR_W     = $clog2(CELL_COUNT);
  localparam int CNT_W      = $clog2(CELL_COUNT + 1);
  localparam int ROW_W      = 5;
  localparam int COL_W      = 7;
  localparam int CELL_W     = 16;

  localparam logic [7:0] CHAR_NL    = 8'd10;
  localparam logic [7:0] CHAR_TAB   = 8'd9;
  localparam logic [7:0] CHAR_CR    = 8'd13;
  localparam logic [7:0] CHAR_BLANK = 8'h20;
  localparam logic [7:0] ATTR_RESET = 8'h0F;

  typedef enum logic [1:0] {
    ACT_PUT    = 2'd0,
    ACT_REMOVE = 2'd1,
    ACT_CLEAR  = 2'd2,
    ACT_READ   = 2'd3
  } action_t;

  typedef enum logic [2:0] {
    ST_INIT,
    ST_IDLE,
    ST_COPY,
    ST_FILL,
    ST_PUT,
    ST_CLEAR,
    ST_READ
  } state_t;

  typedef struct packed {
    action_t     action;
    logic [7:0]  char_code;
    logic [10:0] read_index;
  } in_item_t;

  typedef struct packed {
    logic [4:0]  cursor_row_out;
    logic [6:0]  cursor_column_out;
    logic [15:0] cell_value;
  } out_item_t;

endpackage

### sv/tccw_ram.sv
// Generic simple dual-port RAM: one write port, one registered read port.
module tccw_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 2000
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

### sv/text_console_cell_writer.sv
// Top level of the text console cell writer: sequencer, cursor and cell store.
// Put or remove without scroll answers in the next cycle (next item may follow
// at once); read answers via ST_READ; clear walks the store; put on the last row
// scrolls first (copy, fill, then put). Copy and fill walk the store through its
// single write port, one cell per cycle. Receiver cannot stall; done lasts one
// cycle. Reset: synchronous; a clearing pass blanks the store.
module text_console_cell_writer
  import tccw_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  output logic        busy,
  input  in_item_t    cmd,
  output logic        done,
  output out_item_t   result,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [7:0]  cfg_data
);

  // sequencer and counter
  state_t            state, state_next;
  logic [CNT_W-1:0]  cnt, cnt_next;
  logic              pend, pend_next;     // copy read in flight

  // cursor and attribute
  logic [ROW_W-1:0]  row, row_next;
  logic [COL_W-1:0]  col, col_next;
  logic [7:0]        attr;

  // latched item payload
  logic [7:0]        ch, ch_next;
  logic              in_range, in_range_next;
  logic              done_next;
  out_item_t         result_next;

  // cell store port
  logic              ram_we;
  logic [ADDR_W-1:0] ram_waddr, ram_raddr;
  logic [CELL_W-1:0] ram_wdata, ram_rdata;

  // put and remove decode
  logic [7:0]        put_ch;
  logic [ROW_W-1:0]  put_row, rm_row, idx_row;
  logic [COL_W-1:0]  put_col, rm_col, idx_col;
  logic [COL_W:0]    tab_sum;
  logic              put_wr, rm_wr;
  logic [ADDR_W-1:0] cell_addr;
  logic [CELL_W-1:0] blank;
  logic              accept;

  assign busy      = (state != ST_IDLE);
  assign accept    = start && !busy;
  assign cfg_ready = 1'b1;
  assign blank     = {attr, CHAR_BLANK};

  tccw_ram #(
    .WIDTH (CELL_W),
    .DEPTH (CELL_COUNT)
  ) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  // Put: newline, tab (saturating), carriage return, or printable with wrap.
  // After a scroll the latched character is used.
  always_comb begin
    put_ch  = (state == ST_PUT) ? ch : cmd.char_code;
    put_row = row;
    put_col = col;
    put_wr  = 1'b0;
    tab_sum = {1'b0, col} + (COL_W + 1)'(TAB_STEP);
    if (put_ch == CHAR_NL) begin
      put_row = row + 1'b1;
      put_col = '0;
    end else if (put_ch == CHAR_TAB) begin
      put_col = (tab_sum > (COL_W + 1)'(COLUMNS - 1)) ? COL_W'(COLUMNS - 1)
                                                      : tab_sum[COL_W-1:0];
    end else if (put_ch == CHAR_CR) begin
      put_col = '0;
    end else begin
      put_wr = 1'b1;
      if (col >= COL_W'(COLUMNS - 1)) begin
        put_row = row + 1'b1;
        put_col = '0;
      end else begin
        put_col = col + 1'b1;
      end
    end
  end

  // Remove: step back one cell, up a line at column zero; origin stays put.
  always_comb begin
    rm_row = row;
    rm_col = col;
    rm_wr  = 1'b1;
    if (col == '0) begin
      if (row == '0) begin
        rm_wr = 1'b0;
      end else begin
        rm_row = row - 1'b1;
        rm_col = COL_W'(COLUMNS - 1);
      end
    end else begin
      rm_col = col - 1'b1;
    end
  end

  // One shared row * COLUMNS + column index unit.
  always_comb begin
    if (state == ST_IDLE && cmd.action == ACT_REMOVE) begin
      idx_row = rm_row;
      idx_col = rm_col;
    end else begin
      idx_row = row;
      idx_col = col;
    end
    cell_addr = ADDR_W'(32'(idx_row) * COLUMNS + 32'(idx_col));
  end

  // Next state.
  always_comb begin
    state_next = state;
    case (state)
      ST_INIT: begin
        if (cnt == CNT_W'(CELL_COUNT - 1)) state_next = ST_IDLE;
      end
      ST_IDLE: begin
        if (accept) begin
          case (cmd.action)
            ACT_PUT: begin
              if (row >= ROW_W'(ROWS - 1)) state_next = ST_COPY;
            end
            ACT_CLEAR: state_next = ST_CLEAR;
            ACT_READ:  state_next = ST_READ;
            default:   state_next = ST_IDLE;
          endcase
        end
      end
      ST_COPY: begin
        if (cnt == CNT_W'(CELL_COUNT)) state_next = ST_FILL;
      end
      ST_FILL: begin
        if (cnt == CNT_W'(CELL_COUNT - 1)) state_next = ST_PUT;
      end
      ST_PUT:  state_next = ST_IDLE;
      ST_CLEAR: begin
        if (cnt == CNT_W'(CELL_COUNT - 1)) state_next = ST_IDLE;
      end
      ST_READ: state_next = ST_IDLE;
      default: state_next = ST_IDLE;
    endcase
  end

  // Datapath and store control.
  always_comb begin
    ram_we        = 1'b0;
    ram_waddr     = cell_addr;
    ram_wdata     = blank;
    ram_raddr     = cnt[ADDR_W-1:0];
    row_next      = row;
    col_next      = col;
    cnt_next      = cnt;
    pend_next     = 1'b0;
    ch_next       = ch;
    in_range_next = in_range;
    done_next     = 1'b0;
    result_next   = result;
    case (state)
      ST_INIT: begin
        // reset pass always uses the reset attribute
        ram_we    = 1'b1;
        ram_waddr = cnt[ADDR_W-1:0];
        ram_wdata = {ATTR_RESET, CHAR_BLANK};
        cnt_next  = cnt + 1'b1;
      end
      ST_IDLE: begin
        if (accept) begin
          case (cmd.action)
            ACT_PUT: begin
              if (row >= ROW_W'(ROWS - 1)) begin
                // last row: scroll first, copy starts reading row one
                ch_next  = cmd.char_code;
                cnt_next = CNT_W'(COLUMNS);
              end else begin
                ram_we      = put_wr;
                ram_wdata   = {attr, put_ch};
                row_next    = put_row;
                col_next    = put_col;
                done_next   = 1'b1;
                result_next = {put_row, put_col, 16'h0000};
              end
            end
            ACT_REMOVE: begin
              ram_we      = rm_wr;
              row_next    = rm_row;
              col_next    = rm_col;
              done_next   = 1'b1;
              result_next = {rm_row, rm_col, 16'h0000};
            end
            ACT_CLEAR: begin
              cnt_next = '0;
            end
            ACT_READ: begin
              ram_raddr     = ADDR_W'(cmd.read_index);
              in_range_next = (32'(cmd.read_index) < 32'(CELL_COUNT));
            end
            default: begin
              done_next = 1'b0;
            end
          endcase
        end
      end
      ST_COPY: begin
        // read cell cnt, write the one read last cycle a line higher
        if (cnt != CNT_W'(CELL_COUNT)) begin
          pend_next = 1'b1;
          cnt_next  = cnt + 1'b1;
        end else begin
          cnt_next  = CNT_W'(CELL_COUNT - COLUMNS);
        end
        if (pend) begin
          ram_we    = 1'b1;
          ram_waddr = ADDR_W'(cnt - CNT_W'(COLUMNS + 1));
          ram_wdata = ram_rdata;
        end
      end
      ST_FILL: begin
        ram_we    = 1'b1;
        ram_waddr = cnt[ADDR_W-1:0];
        cnt_next  = cnt + 1'b1;
        if (cnt == CNT_W'(CELL_COUNT - 1)) begin
          row_next = ROW_W'(ROWS - 2);
          col_next = '0;
        end
      end
      ST_PUT: begin
        ram_we      = put_wr;
        ram_wdata   = {attr, put_ch};
        row_next    = put_row;
        col_next    = put_col;
        done_next   = 1'b1;
        result_next = {put_row, put_col, 16'h0000};
      end
      ST_CLEAR: begin
        ram_we    = 1'b1;
        ram_waddr = cnt[ADDR_W-1:0];
        cnt_next  = cnt + 1'b1;
        if (cnt == CNT_W'(CELL_COUNT - 1)) begin
          row_next    = '0;
          col_next    = '0;
          done_next   = 1'b1;
          result_next = '0;
        end
      end
      ST_READ: begin
        done_next   = 1'b1;
        result_next = {row, col, in_range ? ram_rdata : 16'h0000};
      end
      default: begin
        done_next = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_INIT;
      cnt   <= '0;
      pend  <= 1'b0;
      row   <= '0;
      col   <= '0;
      attr  <= ATTR_RESET;
      done  <= 1'b0;
    end else begin
      state <= state_next;
      cnt   <= cnt_next;
      pend  <= pend_next;
      row   <= row_next;
      col   <= col_next;
      done  <= done_next;
      if (cfg_valid && cfg_ready) begin
        attr <= cfg_data;
      end
    end
  end

  // payload, no reset
  always_ff @(posedge clk) begin
    ch       <= ch_next;
    in_range <= in_range_next;
    result   <= result_next;
  end

endmodule

### sv/tccw_checker.sv
// Port-level checker for the text console cell writer, bound to the top level.
module tccw_checker
  import tccw_pkg::*;
(
  input logic       clk,
  input logic       rst,
  input logic       start,
  input logic       busy,
  input in_item_t   cmd,
  input logic       done,
  input out_item_t  result,
  input logic       cfg_valid,
  input logic       cfg_ready,
  input logic [7:0] cfg_data
);

  // reset starts the clearing pass and shows no result
  a_reset_busy: assert property (@(posedge clk) rst |=> busy && !done)
    else $error("not busy after reset");

  // a read goes busy after it is taken, then answers with done
  a_read_latency: assert property (@(posedge clk) disable iff (rst)
    (start && !busy && cmd.action == ACT_READ) |=> busy ##1 done)
    else $error("read result late");

  // clear walks the store, so the block goes busy
  a_clear_busy: assert property (@(posedge clk) disable iff (rst)
    (start && !busy && cmd.action == ACT_CLEAR) |=> busy && !done)
    else $error("clear did not go busy");

  // cursor reported stays on the screen
  a_cursor_range: assert property (@(posedge clk) disable iff (rst)
    done |-> (32'(result.cursor_row_out) < ROWS) &&
             (32'(result.cursor_column_out) < COLUMNS))
    else $error("cursor off screen");

endmodule

bind text_console_cell_writer tccw_checker u_tccw_checker (.*);

### dv/console_checker.sv
// Checker for the text console cell writer: shadow screen, cursor tracking and result compare.
module console_checker
  import tccw_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  input  logic       start,
  input  logic       busy,
  input  in_item_t   cmd,
  input  logic       done,
  input  out_item_t  result,
  input  logic       cfg_valid,
  input  logic       cfg_ready,
  input  logic [7:0] cfg_data,
  output int         mismatch_count,
  output int         replies_due
);
  timeunit 1ns;
  timeprecision 1ps;

  logic [CELL_W-1:0] shadow_screen [CELL_COUNT];
  logic [ROW_W-1:0]  cur_row;
  logic [COL_W-1:0]  cur_col;
  logic [7:0]        attr;
  out_item_t         reply_q [$];

  function automatic logic [CELL_W-1:0] blank_word();
    return {attr, CHAR_BLANK};
  endfunction

  function automatic void blank_all();
    for (int i = 0; i < CELL_COUNT; i++) shadow_screen[i] = blank_word();
  endfunction

  // Applies one command to the shadow state and returns the reply it should produce.
  function automatic out_item_t predict_reply(in_item_t c);
    out_item_t r;
    int        col_next;
    r = '0;
    case (c.action)
      ACT_PUT: begin
        // bottom row reached: shift everything up a line before handling the char
        if (cur_row >= ROWS - 1) begin
          for (int i = COLUMNS; i < CELL_COUNT; i++) shadow_screen[i - COLUMNS] = shadow_screen[i];
          for (int i = CELL_COUNT - COLUMNS; i < CELL_COUNT; i++) shadow_screen[i] = blank_word();
          cur_row = ROW_W'(ROWS - 2);
          cur_col = '0;
        end
        if (c.char_code == CHAR_NL) begin
          cur_row++;
          cur_col = '0;
        end else if (c.char_code == CHAR_TAB) begin
          col_next = cur_col + TAB_STEP;
          if (col_next > COLUMNS - 1) col_next = COLUMNS - 1;
          cur_col = COL_W'(col_next);
        end else if (c.char_code == CHAR_CR) begin
          cur_col = '0;
        end else begin
          shadow_screen[cur_row * COLUMNS + cur_col] = {attr, c.char_code};
          if (cur_col >= COLUMNS - 1) begin
            cur_row++;
            cur_col = '0;
          end else begin
            cur_col++;
          end
        end
      end
      ACT_REMOVE: begin
        if (!(cur_row == 0 && cur_col == 0)) begin
          if (cur_col == 0) begin
            cur_row--;
            cur_col = COL_W'(COLUMNS - 1);
          end else begin
            cur_col--;
          end
          shadow_screen[cur_row * COLUMNS + cur_col] = blank_word();
        end
      end
      ACT_CLEAR: begin
        blank_all();
        cur_row = '0;
        cur_col = '0;
      end
      default: begin
        if (c.read_index < CELL_COUNT) r.cell_value = shadow_screen[c.read_index];
      end
    endcase
    r.cursor_row_out    = cur_row;
    r.cursor_column_out = cur_col;
    return r;
  endfunction

  function automatic void check_field(string what, int want, int got);
    if (want != got) begin
      $display("%0t: %s mismatch, expected 0x%0h, got 0x%0h", $time, what, want, got);
      mismatch_count++;
    end
  endfunction

  always @(posedge clk) begin
    out_item_t want;
    if (rst) begin
      attr           = ATTR_RESET;
      cur_row        = '0;
      cur_col        = '0;
      mismatch_count = 0;
      blank_all();
      reply_q.delete();
    end else begin
      // results first: a reply and a new command can share an edge
      if (done) begin
        if (reply_q.size() == 0) begin
          $display("%0t: result with no command pending, got row %0d column %0d value 0x%0h",
                   $time, result.cursor_row_out, result.cursor_column_out, result.cell_value);
          mismatch_count++;
        end else begin
          want = reply_q.pop_front();
          check_field("cursor_row_out", want.cursor_row_out, result.cursor_row_out);
          check_field("cursor_column_out", want.cursor_column_out, result.cursor_column_out);
          check_field("cell_value", want.cell_value, result.cell_value);
        end
      end
      // an item taken at this edge still sees the old attribute
      if (start && !busy) reply_q.push_back(predict_reply(cmd));
      if (cfg_valid && cfg_ready) attr = cfg_data;
    end
    replies_due <= reply_q.size();
  end

endmodule

### dv/tb_top.sv
// Testbench top for the text console cell writer: clock, reset, stimulus and verdict.
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;
  import tccw_pkg::*;

  logic       clk       = 1'b0;
  logic       rst       = 1'b1;
  logic       start     = 1'b0;
  logic       busy;
  in_item_t   cmd       = '0;
  logic       done;
  out_item_t  result;
  logic       cfg_valid = 1'b0;
  logic       cfg_ready;
  logic [7:0] cfg_data  = '0;

  int mismatch_count;
  int replies_due;
  int items_sent = 0;   // items accepted so far
  int calm_left  = 0;   // items left in the current back-to-back stretch

  // 50 MHz clock
  initial begin
    forever #10 clk = ~clk;
  end

  text_console_cell_writer DUT (
    .clk       (clk),
    .rst       (rst),
    .start     (start),
    .busy      (busy),
    .cmd       (cmd),
    .done      (done),
    .result    (result),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_data  (cfg_data)
  );

  console_checker u_checker (
    .clk            (clk),
    .rst            (rst),
    .start          (start),
    .busy           (busy),
    .cmd            (cmd),
    .done           (done),
    .result         (result),
    .cfg_valid      (cfg_valid),
    .cfg_ready      (cfg_ready),
    .cfg_data       (cfg_data),
    .mismatch_count (mismatch_count),
    .replies_due    (replies_due)
  );

  // Idle cycles before the next item are drawn at random, with occasional
  // stretches of items with no gap so back-to-back issue is exercised too.
  function automatic int next_gap();
    if (calm_left > 0) begin
      calm_left--;
      return 0;
    end
    if ($urandom_range(0, 31) == 0) calm_left = $urandom_range(16, 64);
    return $urandom_range(0, 7);
  endfunction

  // Mostly printable ASCII; now and then any byte, control codes included.
  function automatic logic [7:0] text_char();
    if ($urandom_range(0, 15) == 0) return 8'($urandom);
    return 8'($urandom_range(8'h20, 8'h7E));
  endfunction

  // Half the reads span the full 11-bit index (out-of-range too); the rest
  // land near line starts, where text actually sits.
  function automatic logic [10:0] read_spot();
    if ($urandom_range(0, 1) == 0) return 11'($urandom);
    return 11'($urandom_range(0, ROWS - 1) * COLUMNS + $urandom_range(0, 15));
  endfunction

  // Present one item and hold it until accepted (start high, busy low at an edge).
  // start is only lowered when a gap is drawn, so a zero-gap follow-on item
  // keeps it high with a single assignment in that step.
  task automatic issue(action_t act, logic [7:0] ch, logic [10:0] idx);
    int gap;
    gap = next_gap();
    if (gap > 0) begin
      start <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    start <= 1'b1;
    cmd   <= '{action: act, char_code: ch, read_index: idx};
    @(posedge clk);
    while (busy) @(posedge clk);
    items_sent++;
  endtask

  // Stop issuing and wait for every reply and for the sequencer to go idle.
  // replies_due is registered in the checker, hence the edge before the first look.
  task automatic wait_idle();
    start <= 1'b0;
    @(posedge clk);
    while (replies_due != 0 || busy) @(posedge clk);
  endtask

  task automatic write_attr(logic [7:0] value);
    wait_idle();
    cfg_valid <= 1'b1;
    cfg_data  <= value;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    cfg_valid <= 1'b0;
  endtask

  // Random traffic: mostly lines of text ended by newline or CR, which drive
  // the cursor down to the bottom row and into scrolling; mixed with reads,
  // backspace runs, tab runs (column saturation), newline bursts, the odd
  // clear and fully random noise items.
  task automatic run_phase(int count);
    int stop_at;
    int kind;
    int len;
    stop_at = items_sent + count;
    while (items_sent < stop_at) begin
      kind = $urandom_range(0, 99);
      if (kind < 45) begin
        len = ($urandom_range(0, 9) < 7) ? $urandom_range(0, 12) : $urandom_range(40, 100);
        repeat (len) issue(ACT_PUT, text_char(), 11'($urandom));
        issue(ACT_PUT, ($urandom_range(0, 4) != 0) ? CHAR_NL : CHAR_CR, 11'($urandom));
      end else if (kind < 60) begin
        repeat ($urandom_range(1, 4)) issue(ACT_READ, 8'($urandom), read_spot());
      end else if (kind < 70) begin
        repeat ($urandom_range(1, 6)) issue(ACT_REMOVE, 8'($urandom), 11'($urandom));
      end else if (kind < 78) begin
        repeat ($urandom_range(1, 22)) issue(ACT_PUT, CHAR_TAB, 11'($urandom));
        issue(ACT_PUT, text_char(), 11'($urandom));
      end else if (kind < 86) begin
        repeat ($urandom_range(1, 12)) issue(ACT_PUT, CHAR_NL, 11'($urandom));
      end else if (kind < 89) begin
        issue(ACT_CLEAR, 8'($urandom), 11'($urandom));
      end else begin
        issue(action_t'($urandom_range(0, 3)), 8'($urandom), 11'($urandom));
      end
    end
  endtask

  initial begin
    // reset held at the start; the block then runs its clearing pass, which
    // shows as busy and simply delays the first accept
    repeat (10) @(posedge clk);
    rst <= 1'b0;

    // directed, reset attribute: blank store at both ends and past the end
    issue(ACT_READ, CHAR_BLANK, 11'd0);
    issue(ACT_READ, CHAR_BLANK, 11'(CELL_COUNT - 1));
    issue(ACT_READ, CHAR_BLANK, 11'(CELL_COUNT));
    issue(ACT_READ, CHAR_BLANK, 11'h7FF);
    // backspace at the origin does nothing
    issue(ACT_REMOVE, 8'h00, 11'd0);
    // byte extremes, tab, carriage return, newline
    issue(ACT_PUT, 8'h41, 11'd0);
    issue(ACT_PUT, 8'h00, 11'd0);
    issue(ACT_PUT, 8'hFF, 11'h7FF);
    issue(ACT_PUT, CHAR_TAB, 11'd0);
    issue(ACT_PUT, CHAR_CR, 11'd0);
    issue(ACT_PUT, CHAR_NL, 11'd0);
    // backspace at line start goes to the last column of the row above
    issue(ACT_REMOVE, 8'h00, 11'd0);
    // printable in the last column wraps to the next line
    issue(ACT_PUT, 8'h7E, 11'd0);
    issue(ACT_READ, 8'h00, 11'(COLUMNS - 1));
    issue(ACT_READ, 8'h00, 11'd0);
    issue(ACT_REMOVE, 8'h00, 11'd0);
    issue(ACT_READ, 8'h00, 11'(COLUMNS - 1));
    issue(ACT_CLEAR, 8'h00, 11'd0);
    issue(ACT_READ, 8'h00, 11'd0);

    // random phases, attribute changed between them: both extremes, then random
    for (int p = 0; p < 5; p++) begin
      write_attr((p == 0) ? 8'hFF : (p == 1) ? 8'h00 : 8'($urandom_range(1, 254)));
      run_phase(216);
    end

    wait_idle();
    // quiet period: any stray result shows up as an unexpected one
    repeat (CELL_COUNT + 8) @(posedge clk);
    if (mismatch_count == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

  // Watchdog: even if every item scrolled (gaps included) the run would need
  // under 50 ms; allow four times that.
  initial begin
    #200ms;
    $display("Testbench completed WITH ERRORS");
    $finish;
  end

endmodule
